FILE: rtl/eim_pkg.sv
package eim_pkg;

   typedef struct packed {
      logic [1:0]         func;
      logic [63:0]        timestamp_us;
      logic               surface_present;
      logic signed [15:0] elevator_angle;
      logic [7:0]         claimed_law;
      logic               air_present;
      logic [3:0]         air_valid_bits;
      logic signed [15:0] alpha;
   } eim_req_type;

   typedef struct packed {
      logic       trip;
      logic [4:0] flags;
      logic [31:0] violation_total;
   } eim_rsp_type;

   typedef enum logic [1:0] {
      FUNC_FRAME = 2'd0,
      FUNC_WARM  = 2'd1,
      FUNC_COLD  = 2'd2
   } eim_func_type;

   localparam int FLAG_NO_DATA   = 0;
   localparam int FLAG_AUTHORITY = 1;
   localparam int FLAG_SLEW      = 2;
   localparam int FLAG_REVERSION = 3;
   localparam int FLAG_ALPHA     = 4;

   localparam logic [7:0] CSR_AUTHORITY_LIMIT   = 8'd0;
   localparam logic [7:0] CSR_SLEW_LIMIT        = 8'd1;
   localparam logic [7:0] CSR_ALPHA_LIMIT       = 8'd2;
   localparam logic [7:0] CSR_NOSE_DOWN_MINIMUM = 8'd3;
   localparam logic [7:0] CSR_TRIP_COUNT        = 8'd4;
   localparam logic [7:0] CSR_VALID_MASK        = 8'd5;
   localparam logic [7:0] CSR_NORMAL_LAW_CODE   = 8'd6;
   localparam logic [7:0] CSR_DEFAULT_INTERVAL  = 8'd7;

   localparam logic [14:0] AUTHORITY_LIMIT_RST   = 15'd2550;
   localparam logic [16:0] SLEW_LIMIT_RST        = 17'd5000;
   localparam logic [15:0] ALPHA_LIMIT_RST       = 16'd1500;
   localparam logic [15:0] NOSE_DOWN_MINIMUM_RST = 16'd25;
   localparam logic [7:0]  TRIP_COUNT_RST        = 8'd3;
   localparam logic [3:0]  VALID_MASK_RST        = 4'hF;
   localparam logic [7:0]  NORMAL_LAW_CODE_RST   = 8'd0;
   localparam logic [31:0] DEFAULT_INTERVAL_RST  = 32'd50000;

   localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
   localparam logic [7:0]  CONSEC_MAX   = 8'hFF;

   typedef struct packed {
      logic [14:0]        authority_limit;
      logic [16:0]        slew_limit;
      logic signed [15:0] alpha_limit;
      logic signed [15:0] nose_down_minimum;
      logic [7:0]         trip_count;
      logic [3:0]         valid_mask;
      logic [7:0]         normal_law_code;
      logic [31:0]        default_interval;
   } eim_cfg_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [4:0]  flags;
      logic        slew_en;
      logic [31:0] dt;
      logic [15:0] delta_mag;
   } eim_s1_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [4:0]  flags;
      logic        slew_en;
      logic [35:0] move;
      logic [48:0] allowance;
   } eim_s2_type;

endpackage

FILE: rtl/envelope_invariant_monitor.sv
// Control-frame envelope monitor. One request enters per clock while req_stall
// is low; a frame check presents its result on rsp_ after the input check,
// slew multiply and counter update, each of which ends in a register, while
// warm and cold restarts and unused function codes return nothing. The three
// stages are elastic, so a stalled result holds only the stages behind it that
// are full, and req_stall rises only when the whole pipeline is occupied.
// Configuration registers are written through the csr_ port, which is always
// ready; write them only while no request is in flight.
module envelope_invariant_monitor (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  eim_pkg::eim_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output eim_pkg::eim_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [7:0]           csr_index,
   input  logic [31:0]          csr_wdata
);
   import eim_pkg::*;

   eim_cfg_type cfg;
   eim_s1_type  s1;
   eim_s2_type  s2;
   logic        s1_valid;
   logic        s2_valid;
   logic        adv3;
   logic        adv2;
   logic        adv1;
   logic        accept;

   assign adv2      = !s2_valid || adv3;
   assign adv1      = !s1_valid || adv2;
   assign req_stall = !adv1;
   assign accept    = req_valid && adv1;

   eim_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   eim_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .advance   (adv1),
      .req_valid (req_valid),
      .req_data  (req_data),
      .cfg       (cfg),
      .s1_valid  (s1_valid),
      .s1        (s1)
   );

   eim_slew_mult u_slew_mult (
      .clock      (clock),
      .reset      (reset),
      .advance    (adv2),
      .s1_valid   (s1_valid),
      .s1         (s1),
      .slew_limit (cfg.slew_limit),
      .s2_valid   (s2_valid),
      .s2         (s2)
   );

   eim_tally u_tally (
      .clock      (clock),
      .reset      (reset),
      .s2_valid   (s2_valid),
      .s2         (s2),
      .trip_count (cfg.trip_count),
      .rsp_stall  (rsp_stall),
      .advance    (adv3),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   a_no_data_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.flags[FLAG_NO_DATA] |-> rsp_data.flags[4:1] == 4'd0)
      else $error("no-data frame carries other flags");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty result register");

   a_single_trip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.flags != 5'd0) && (cfg.trip_count <= 8'd1)
      |-> rsp_data.trip)
      else $error("violation did not latch trip at unit trip count");

endmodule

FILE: rtl/eim_csr.sv
module eim_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [7:0]           csr_index,
   input  logic [31:0]          csr_wdata,
   output logic                 csr_ready,
   output eim_pkg::eim_cfg_type cfg
);
   import eim_pkg::*;

   eim_cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.authority_limit   <= AUTHORITY_LIMIT_RST;
         cfg_ff.slew_limit        <= SLEW_LIMIT_RST;
         cfg_ff.alpha_limit       <= ALPHA_LIMIT_RST;
         cfg_ff.nose_down_minimum <= NOSE_DOWN_MINIMUM_RST;
         cfg_ff.trip_count        <= TRIP_COUNT_RST;
         cfg_ff.valid_mask        <= VALID_MASK_RST;
         cfg_ff.normal_law_code   <= NORMAL_LAW_CODE_RST;
         cfg_ff.default_interval  <= DEFAULT_INTERVAL_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_AUTHORITY_LIMIT:   cfg_ff.authority_limit   <= csr_wdata[14:0];
            CSR_SLEW_LIMIT:        cfg_ff.slew_limit        <= csr_wdata[16:0];
            CSR_ALPHA_LIMIT:       cfg_ff.alpha_limit       <= csr_wdata[15:0];
            CSR_NOSE_DOWN_MINIMUM: cfg_ff.nose_down_minimum <= csr_wdata[15:0];
            CSR_TRIP_COUNT:        cfg_ff.trip_count        <= csr_wdata[7:0];
            CSR_VALID_MASK:        cfg_ff.valid_mask        <= csr_wdata[3:0];
            CSR_NORMAL_LAW_CODE:   cfg_ff.normal_law_code   <= csr_wdata[7:0];
            CSR_DEFAULT_INTERVAL:  cfg_ff.default_interval  <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

FILE: rtl/eim_front.sv
module eim_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 advance,
   input  logic                 req_valid,
   input  eim_pkg::eim_req_type req_data,
   input  eim_pkg::eim_cfg_type cfg,
   output logic                 s1_valid,
   output eim_pkg::eim_s1_type  s1
);
   import eim_pkg::*;

   logic [63:0] prev_time_ff;
   logic [15:0] prev_elev_ff;
   logic        hist_ff;
   logic        s1_valid_ff;
   eim_s1_type  s1_ff;
   eim_s1_type  s1_in;

   logic [63:0]        ts_delta;
   logic               ts_ahead;
   logic [31:0]        dt;
   logic signed [16:0] elev_diff;
   logic [16:0]        diff_neg;
   logic [15:0]        delta_mag;
   logic [15:0]        elev_u;
   logic [15:0]        elev_mag;
   logic               auth_flag;
   logic               all_valid;
   logic               rev_flag;
   logic               alpha_flag;
   logic               is_frame;
   logic               is_restart;

   assign ts_ahead  = req_data.timestamp_us > prev_time_ff;
   assign ts_delta  = req_data.timestamp_us - prev_time_ff;
   assign dt        = (hist_ff && ts_ahead)
                      ? ((|ts_delta[63:32]) ? 32'hFFFF_FFFF : ts_delta[31:0])
                      : cfg.default_interval;

   assign elev_diff = {req_data.elevator_angle[15], req_data.elevator_angle}
                      - {prev_elev_ff[15], prev_elev_ff};
   assign diff_neg  = 17'd0 - elev_diff;
   assign delta_mag = elev_diff[16] ? diff_neg[15:0] : elev_diff[15:0];

   assign elev_u    = req_data.elevator_angle;
   assign elev_mag  = elev_u[15] ? (16'd0 - elev_u) : elev_u;
   assign auth_flag = elev_mag > {1'b0, cfg.authority_limit};

   assign all_valid  = (req_data.air_valid_bits & cfg.valid_mask) == cfg.valid_mask;
   assign rev_flag   = req_data.air_present && !all_valid
                       && (req_data.claimed_law == cfg.normal_law_code);
   assign alpha_flag = req_data.air_present && all_valid
                       && (req_data.alpha > cfg.alpha_limit)
                       && (req_data.elevator_angle < cfg.nose_down_minimum);

   assign is_frame   = req_data.func == FUNC_FRAME;
   assign is_restart = (req_data.func == FUNC_WARM) || (req_data.func == FUNC_COLD);

   always_comb begin
      s1_in           = '0;
      s1_in.func      = req_data.func;
      s1_in.dt        = dt;
      s1_in.delta_mag = delta_mag;
      s1_in.slew_en   = req_data.surface_present && hist_ff && (dt != 32'd0);
      if (!req_data.surface_present) begin
         s1_in.flags[FLAG_NO_DATA] = 1'b1;
      end else begin
         s1_in.flags[FLAG_AUTHORITY] = auth_flag;
         s1_in.flags[FLAG_REVERSION] = rev_flag;
         s1_in.flags[FLAG_ALPHA]     = alpha_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff      <= 1'b0;
         prev_time_ff <= '0;
         prev_elev_ff <= '0;
      end else if (accept) begin
         if (is_restart) begin
            hist_ff <= 1'b0;
         end else if (is_frame) begin
            prev_time_ff <= req_data.timestamp_us;
            hist_ff      <= req_data.surface_present;
            if (req_data.surface_present) begin
               prev_elev_ff <= req_data.elevator_angle;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1       = s1_ff;

endmodule

FILE: rtl/eim_slew_mult.sv
module eim_slew_mult (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                s1_valid,
   input  eim_pkg::eim_s1_type s1,
   input  logic [16:0]         slew_limit,
   output logic                s2_valid,
   output eim_pkg::eim_s2_type s2
);
   import eim_pkg::*;

   logic       s2_valid_ff;
   eim_s2_type s2_ff;
   eim_s2_type s2_in;

   always_comb begin
      s2_in.func      = s1.func;
      s2_in.flags     = s1.flags;
      s2_in.slew_en   = s1.slew_en;
      // |delta| * 1e6 against limit * dt keeps the rate compare division free
      s2_in.move      = {20'd0, s1.delta_mag} * {16'd0, USEC_PER_SEC};
      s2_in.allowance = {32'd0, slew_limit} * {17'd0, s1.dt};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid) begin
         s2_ff <= s2_in;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2       = s2_ff;

endmodule

FILE: rtl/eim_tally.sv
module eim_tally (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 s2_valid,
   input  eim_pkg::eim_s2_type  s2,
   input  logic [7:0]           trip_count,
   input  logic                 rsp_stall,
   output logic                 advance,
   output logic                 rsp_valid,
   output eim_pkg::eim_rsp_type rsp_data
);
   import eim_pkg::*;

   logic        rsp_valid_ff;
   eim_rsp_type rsp_ff;
   logic        trip_ff;
   logic        trip_in;
   logic [7:0]  consec_ff;
   logic [7:0]  consec_in;
   logic [31:0] viol_ff;
   logic [31:0] viol_in;
   logic [4:0]  flags;
   logic        load;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign load    = advance && s2_valid;

   always_comb begin
      flags             = s2.flags;
      flags[FLAG_SLEW]  = s2.slew_en && ({13'd0, s2.move} > s2.allowance);
      trip_in           = trip_ff;
      consec_in         = consec_ff;
      viol_in           = viol_ff;
      case (s2.func)
         FUNC_FRAME: begin
            if (|flags) begin
               viol_in   = viol_ff + 32'd1;
               consec_in = (consec_ff == CONSEC_MAX) ? consec_ff : consec_ff + 8'd1;
               if (consec_in >= trip_count) begin
                  trip_in = 1'b1;
               end
            end else begin
               consec_in = '0;
            end
         end
         FUNC_WARM: begin
            consec_in = '0;
         end
         FUNC_COLD: begin
            consec_in = '0;
            trip_in   = 1'b0;
            viol_in   = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trip_ff      <= 1'b0;
         consec_ff    <= '0;
         viol_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            trip_ff   <= trip_in;
            consec_ff <= consec_in;
            viol_ff   <= viol_in;
         end
         if (advance) begin
            rsp_valid_ff <= s2_valid && (s2.func == FUNC_FRAME);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff.trip            <= trip_in;
         rsp_ff.flags           <= flags;
         rsp_ff.violation_total <= viol_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
